[rtl/jvri_pkg.sv]
`timescale 1ns / 1ps

package jvri_pkg;

  // Data words are signed Q4.27, the control period is unsigned Q0.32.
  localparam int DW = 32;
  localparam int PERIOD_W = 32;

  localparam int JOINTS_DEF = 6;
  localparam int WRAP_JOINT_DEF = 5;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 32'd4294967;
  localparam logic signed [DW-1:0] TWO_PI_Q27 = 32'sd843314857;

  typedef enum logic [2:0] {
    KIND_TICK    = 3'd0,
    KIND_VEL_DES = 3'd1,
    KIND_POS     = 3'd2,
    KIND_VEL_MAX = 3'd3,
    KIND_ACCEL   = 3'd4,
    KIND_LOWER   = 3'd5,
    KIND_UPPER   = 3'd6
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP_START,
    ST_STEP_WAIT,
    ST_VEL_UPD,
    ST_POS_WAIT,
    ST_LIM_LO,
    ST_LIM_HI
  } state_e;

  // Saturates a sum with one guard bit back to a data word.
  function automatic logic signed [DW-1:0] sat_word(input logic signed [DW:0] v);
    logic signed [DW-1:0] r;
    if (v[DW] != v[DW-1]) begin
      r = v[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end else begin
      r = v[DW-1:0];
    end
    return r;
  endfunction

endpackage

[rtl/jvri_ser_mul.sv]
`timescale 1ns / 1ps

// Serial shift-and-add multiplier: one multiplier bit per cycle. The result is
// the signed product shifted right by the multiplier width, rounded down.
module jvri_ser_mul #(
  parameter int DW = jvri_pkg::DW,
  parameter int MW = jvri_pkg::PERIOD_W
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [DW-1:0] mcand_i,
  input  logic        [MW-1:0] mplier_i,
  output logic                 done_o,
  output logic signed [DW-1:0] prod_o
);

  localparam int CW = (MW > 1) ? $clog2(MW) : 1;
  localparam logic [CW-1:0] CNT_LAST = CW'(MW - 1);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic signed [DW:0]   hi_q, hi_d;
  logic [MW-1:0]        mr_q, mr_d;
  logic signed [DW-1:0] md_q, md_d;
  logic signed [DW+1:0] sum;

  always_comb begin
    sum    = {hi_q[DW], hi_q} + (mr_q[0] ? {{2{md_q[DW-1]}}, md_q} : '0);
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    hi_d   = hi_q;
    mr_d   = mr_q;
    md_d   = md_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      hi_d   = '0;
      mr_d   = mplier_i;
      md_d   = mcand_i;
    end else if (busy_q) begin
      // Arithmetic shift drops one low product bit per cycle.
      hi_d  = sum[DW+1:1];
      mr_d  = mr_q >> 1;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hi_q <= hi_d;
    mr_q <= mr_d;
    md_q <= md_d;
  end

  assign done_o = done_q;
  assign prod_o = hi_q[DW-1:0];

endmodule

[rtl/joint_velocity_ramp_integrator_unit.sv]
`timescale 1ns / 1ps

// Acceleration-limited velocity ramp and position integrator for a set of joints.
//
// Input channel (in_valid_i / in_stall_o): an item is taken when valid is high
// and stall is low. A setting item loads one value of one joint and leaves the
// block idle, so setting items may follow each other on every cycle. A tick
// item ramps each joint's velocity, integrates its position and produces one
// output item per joint in joint order, the final one flagged with last_o.
// The input stalls from the cycle after a tick is taken until its last output
// item has been loaded into the output register.
// Timing: every product with the control period comes from a bit-serial
// multiplier, one period bit per cycle, and each joint needs two of them,
// the velocity step and then the position increment, before its lower and
// upper limit stages.
// Output channel (out_valid_o / out_stall_i): one output register. While the
// receiver stalls, the item is held and the joint sequence waits before loading
// the next one; the next tick is accepted while the final item still waits.
// Reset clears all joint state to zero and sets the period to about 1 ms.
// The user must write the control period through cfg_wr_en_i / cfg_wr_data_i
// only when idle; the block itself does not enforce this.
module joint_velocity_ramp_integrator_unit #(
  parameter int JOINTS = jvri_pkg::JOINTS_DEF,
  parameter int WRAP_JOINT = jvri_pkg::WRAP_JOINT_DEF,
  localparam int JW = (JOINTS > 1) ? $clog2(JOINTS) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [2:0]                    kind_i,
  input  logic [JW-1:0]                 joint_i,
  input  logic signed [jvri_pkg::DW-1:0] value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [JW-1:0]                 out_joint_o,
  output logic signed [jvri_pkg::DW-1:0] position_cmd_o,
  output logic                          last_o,
  input  logic                          cfg_wr_en_i,
  input  logic [jvri_pkg::PERIOD_W-1:0] cfg_wr_data_i
);

  localparam int DW = jvri_pkg::DW;
  localparam logic [JW:0]   JOINTS_C = (JW + 1)'(JOINTS);
  localparam logic [JW-1:0] LAST_C   = JW'(JOINTS - 1);
  localparam bit            WRAP_ON  = (WRAP_JOINT < JOINTS);
  localparam logic [JW-1:0] WRAP_C   = JW'(WRAP_JOINT);

  jvri_pkg::state_e state_q, state_d;

  logic [jvri_pkg::PERIOD_W-1:0] period_q;
  logic [JW-1:0]                 jnt_q, jnt_d;
  logic signed [DW-1:0]          pos_q, pos_d;

  // Per-joint state, each array read at the running joint or the addressed one.
  logic signed [DW-1:0] pos_cmd_q [JOINTS];
  logic signed [DW-1:0] vel_cmd_q [JOINTS];
  logic signed [DW-1:0] vel_des_q [JOINTS];
  logic signed [DW-1:0] vel_max_q [JOINTS];
  logic signed [DW-1:0] accel_q   [JOINTS];
  logic signed [DW-1:0] lower_q   [JOINTS];
  logic signed [DW-1:0] upper_q   [JOINTS];

  logic                 out_vld_q;
  logic [JW-1:0]        out_joint_q;
  logic signed [DW-1:0] out_pos_q;
  logic                 out_last_q;

  logic                 in_acc;
  logic                 set_ok;
  logic signed [DW-1:0] vmax_pos, vmax_neg, vdes_new;

  logic                 mul_start, mul_done;
  logic signed [DW-1:0] mul_mcand, mul_prod;

  logic signed [DW-1:0] acc_cur, vel_cur, des_cur, lo_cur, hi_cur;
  logic signed [DW-1:0] vel_up, vel_dn, vel_new;
  logic signed [DW-1:0] pos_final;
  logic                 is_wrap;
  logic                 out_free, out_load, vel_we;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign set_ok  = in_acc && (jvri_pkg::kind_e'(kind_i) != jvri_pkg::KIND_TICK)
                   && ({1'b0, joint_i} < JOINTS_C);
  assign is_wrap = WRAP_ON && (jnt_q == WRAP_C);

  assign acc_cur = accel_q[jnt_q];
  assign vel_cur = vel_cmd_q[jnt_q];
  assign des_cur = vel_des_q[jnt_q];
  assign lo_cur  = lower_q[jnt_q];
  assign hi_cur  = upper_q[jnt_q];

  // Desired velocity is clamped to the joint's maximum, a negative maximum
  // counting as zero.
  always_comb begin
    vmax_pos = vel_max_q[joint_i][DW-1] ? '0 : vel_max_q[joint_i];
    vmax_neg = -vmax_pos;
    vdes_new = value_i;
    if (vdes_new > vmax_pos) begin
      vdes_new = vmax_pos;
    end
    if (vdes_new < vmax_neg) begin
      vdes_new = vmax_neg;
    end
  end

  // Velocity ramp: the multiplier holds the step, which is never negative.
  // Equal velocities take the lower branch and land on the desired value.
  always_comb begin
    vel_up = jvri_pkg::sat_word({vel_cur[DW-1], vel_cur} + {mul_prod[DW-1], mul_prod});
    vel_dn = jvri_pkg::sat_word({vel_cur[DW-1], vel_cur} - {mul_prod[DW-1], mul_prod});
    if (des_cur > vel_cur) begin
      vel_new = (vel_up > des_cur) ? des_cur : vel_up;
    end else begin
      vel_new = (vel_dn < des_cur) ? des_cur : vel_dn;
    end
  end

  // Upper bound stage: the wrap joint turns back by one revolution, the others
  // clamp. With inverted limits the upper clamp therefore wins.
  always_comb begin
    pos_final = pos_q;
    if (pos_q > hi_cur) begin
      pos_final = is_wrap
                  ? jvri_pkg::sat_word({pos_q[DW-1], pos_q}
                                       - {jvri_pkg::TWO_PI_Q27[DW-1], jvri_pkg::TWO_PI_Q27})
                  : hi_cur;
    end
  end

  assign out_free = !out_vld_q || !out_stall_i;

  always_comb begin
    state_d   = state_q;
    jnt_d     = jnt_q;
    pos_d     = pos_q;
    in_stall_o = 1'b1;
    mul_start = 1'b0;
    mul_mcand = vel_new;
    vel_we    = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      jvri_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i && (jvri_pkg::kind_e'(kind_i) == jvri_pkg::KIND_TICK)) begin
          jnt_d   = '0;
          state_d = jvri_pkg::ST_STEP_START;
        end
      end
      jvri_pkg::ST_STEP_START: begin
        mul_start = 1'b1;
        mul_mcand = acc_cur[DW-1] ? '0 : acc_cur;
        state_d   = jvri_pkg::ST_STEP_WAIT;
      end
      jvri_pkg::ST_STEP_WAIT: begin
        if (mul_done) begin
          state_d = jvri_pkg::ST_VEL_UPD;
        end
      end
      jvri_pkg::ST_VEL_UPD: begin
        vel_we    = 1'b1;
        mul_start = 1'b1;
        mul_mcand = vel_new;
        state_d   = jvri_pkg::ST_POS_WAIT;
      end
      jvri_pkg::ST_POS_WAIT: begin
        if (mul_done) begin
          pos_d   = jvri_pkg::sat_word({pos_cmd_q[jnt_q][DW-1], pos_cmd_q[jnt_q]}
                                       + {mul_prod[DW-1], mul_prod});
          state_d = jvri_pkg::ST_LIM_LO;
        end
      end
      jvri_pkg::ST_LIM_LO: begin
        if (pos_q < lo_cur) begin
          pos_d = is_wrap
                  ? jvri_pkg::sat_word({pos_q[DW-1], pos_q}
                                       + {jvri_pkg::TWO_PI_Q27[DW-1], jvri_pkg::TWO_PI_Q27})
                  : lo_cur;
        end
        state_d = jvri_pkg::ST_LIM_HI;
      end
      jvri_pkg::ST_LIM_HI: begin
        if (out_free) begin
          out_load = 1'b1;
          if (jnt_q == LAST_C) begin
            state_d = jvri_pkg::ST_IDLE;
          end else begin
            jnt_d   = jnt_q + 1'b1;
            state_d = jvri_pkg::ST_STEP_START;
          end
        end
      end
      default: begin
        state_d = jvri_pkg::ST_IDLE;
      end
    endcase
  end

  jvri_ser_mul #(
    .DW (DW),
    .MW (jvri_pkg::PERIOD_W)
  ) u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .mcand_i  (mul_mcand),
    .mplier_i (period_q),
    .done_o   (mul_done),
    .prod_o   (mul_prod)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= jvri_pkg::ST_IDLE;
      jnt_q     <= '0;
      period_q  <= jvri_pkg::PERIOD_RESET;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      jnt_q   <= jnt_d;
      if (cfg_wr_en_i) begin
        period_q <= cfg_wr_data_i;
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < JOINTS; j++) begin
        pos_cmd_q[j] <= '0;
        vel_cmd_q[j] <= '0;
        vel_des_q[j] <= '0;
        vel_max_q[j] <= '0;
        accel_q[j]   <= '0;
        lower_q[j]   <= '0;
        upper_q[j]   <= '0;
      end
    end else begin
      if (set_ok) begin
        case (jvri_pkg::kind_e'(kind_i))
          jvri_pkg::KIND_VEL_DES: vel_des_q[joint_i] <= vdes_new;
          jvri_pkg::KIND_POS:     pos_cmd_q[joint_i] <= value_i;
          jvri_pkg::KIND_VEL_MAX: vel_max_q[joint_i] <= value_i;
          jvri_pkg::KIND_ACCEL:   accel_q[joint_i]   <= value_i;
          jvri_pkg::KIND_LOWER:   lower_q[joint_i]   <= value_i;
          jvri_pkg::KIND_UPPER:   upper_q[joint_i]   <= value_i;
          default: begin
          end
        endcase
      end
      if (vel_we) begin
        vel_cmd_q[jnt_q] <= vel_new;
      end
      if (out_load) begin
        pos_cmd_q[jnt_q] <= pos_final;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    if (out_load) begin
      out_joint_q <= jnt_q;
      out_pos_q   <= pos_final;
      out_last_q  <= (jnt_q == LAST_C);
    end
  end

  assign out_valid_o    = out_vld_q;
  assign out_joint_o    = out_joint_q;
  assign position_cmd_o = out_pos_q;
  assign last_o         = out_last_q;

  // The multiplier only finishes while the sequencer is waiting for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == jvri_pkg::ST_STEP_WAIT || state_q == jvri_pkg::ST_POS_WAIT))
  else $error("multiplier finished outside a wait state");

  // The last flag marks exactly the final joint.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_last_q == (out_joint_q == LAST_C)))
  else $error("last flag does not match the joint index");

  // An item that is not the last one is followed by the next joint's ramp.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && (jnt_q != LAST_C)) |=>
      (state_q == jvri_pkg::ST_STEP_START && jnt_q == $past(jnt_q) + 1'b1))
  else $error("joint sequence did not advance");

  // No tick starts while the multiplier is still working on a previous product.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == jvri_pkg::ST_IDLE) |-> !mul_done)
  else $error("multiplier active while idle");

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

// Self-checking bench for the joint velocity ramp and position integrator.
// Every accepted input item is replayed on a behavioural copy of the joint
// state, and each accepted output item is compared with the oldest position
// that this copy still holds in store.
module tb_top;
  import jvri_pkg::*;

  localparam int NJ = JOINTS_DEF;
  localparam int WRAP = WRAP_JOINT_DEF;

  // Kind code that the block has no use for; such items must be dropped.
  localparam logic [2:0] KIND_UNUSED = 3'd7;

  localparam logic signed [DW-1:0] W_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DW-1:0] W_MIN = 32'sh8000_0000;

  // The pause before a period write covers a whole joint step, the tail a whole tick.
  localparam int SETTLE_CYCLES = 80;
  localparam int TAIL_CYCLES = 500;
  localparam int STALL_LIMIT = 4000;
  localparam int RANDOM_ITEMS = 100;
  localparam int PHASES = 6;

  // Rows of the directed script either use the behavioural copy or name one
  // of the hand-written position sets below.
  localparam int PREDICTED = -1;
  localparam int ZERO_TICK = 0;
  localparam int CLAMP_TICK = 1;
  localparam int WRAP_TICK = 2;

  typedef struct packed {
    logic [2:0]             jnt;
    logic signed [DW-1:0]   pos;
    logic                   last;
  } pos_item_t;

  typedef struct packed {
    logic [2:0]             kind;
    logic [2:0]             jnt;
    logic signed [DW-1:0]   value;
    int                     typed_ref;
  } script_row_t;

  typedef enum logic [1:0] {RX_FLOW, RX_HOLD, RX_COIN, RX_SPARSE} rx_mode_e;

  // Positions that can be read straight off the setting items before them:
  // nothing moves while every velocity is zero, so only the limits act.
  localparam logic signed [DW-1:0] TYPED_POS [3][NJ] = '{
    '{32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0},
    '{W_MAX, -32'sd100, 32'sd0, 32'sd0, 32'sd0, -32'sd1304168791},
    '{W_MAX, -32'sd100, 32'sd0, 32'sd0, 32'sd0, 32'sd1304168790}
  };

  localparam script_row_t SCRIPT [26] = '{
    // A tick straight after reset gives zero everywhere.
    '{KIND_TICK,    3'd0, 32'sd0,           ZERO_TICK},
    // A joint index past the last joint and the unused kind are both dropped.
    '{KIND_POS,     3'd6, 32'sh1234_5678,   PREDICTED},
    '{KIND_UNUSED,  3'd0, W_MAX,            PREDICTED},
    '{KIND_TICK,    3'd7, W_MIN,            ZERO_TICK},
    // Joint 0 parked at full scale between the widest limits; joint 1 with
    // its lower limit above its upper one, so the upper limit wins.
    '{KIND_POS,     3'd0, W_MAX,            PREDICTED},
    '{KIND_UPPER,   3'd0, W_MAX,            PREDICTED},
    '{KIND_LOWER,   3'd0, W_MIN,            PREDICTED},
    '{KIND_LOWER,   3'd1, 32'sd100,         PREDICTED},
    '{KIND_UPPER,   3'd1, -32'sd100,        PREDICTED},
    // The wrap joint below its lower limit is lifted by one turn.
    '{KIND_POS,     3'd5, W_MIN,            PREDICTED},
    '{KIND_UPPER,   3'd5, W_MAX,            PREDICTED},
    '{KIND_TICK,    3'd0, 32'sd0,           CLAMP_TICK},
    // The wrap joint above its upper limit is lowered by one turn.
    '{KIND_POS,     3'd5, W_MAX,            PREDICTED},
    '{KIND_LOWER,   3'd5, W_MIN,            PREDICTED},
    '{KIND_UPPER,   3'd5, 32'sd0,           PREDICTED},
    '{KIND_TICK,    3'd0, 32'sd0,           WRAP_TICK},
    // Joint 2 ramps towards a desired speed clamped to its maximum of 1.0;
    // joint 3 has a negative maximum, so its desired speed is forced to zero.
    '{KIND_UPPER,   3'd2, W_MAX,            PREDICTED},
    '{KIND_LOWER,   3'd2, W_MIN,            PREDICTED},
    '{KIND_VEL_MAX, 3'd2, 32'sh0800_0000,   PREDICTED},
    '{KIND_ACCEL,   3'd2, W_MAX,            PREDICTED},
    '{KIND_VEL_DES, 3'd2, W_MAX,            PREDICTED},
    '{KIND_VEL_MAX, 3'd3, -32'sd5,          PREDICTED},
    '{KIND_VEL_DES, 3'd3, 32'sd1000,        PREDICTED},
    '{KIND_TICK,    3'd0, 32'sd0,           PREDICTED},
    // Reversal: the most negative request is clamped to minus the maximum.
    '{KIND_VEL_DES, 3'd2, W_MIN,            PREDICTED},
    '{KIND_TICK,    3'd0, 32'sd0,           PREDICTED}
  };

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   in_valid_i;
  logic                   in_stall_o;
  logic [2:0]             kind_i;
  logic [2:0]             joint_i;
  logic signed [DW-1:0]   value_i;
  logic                   out_valid_o;
  logic                   out_stall_i;
  logic [2:0]             out_joint_o;
  logic signed [DW-1:0]   position_cmd_o;
  logic                   last_o;
  logic                   cfg_wr_en_i;
  logic [PERIOD_W-1:0]    cfg_wr_data_i;

  // Behavioural copy of the period register and of every joint's state.
  logic [PERIOD_W-1:0]    period_q;
  logic signed [DW-1:0]   j_pos [NJ];
  logic signed [DW-1:0]   j_vel [NJ];
  logic signed [DW-1:0]   j_des [NJ];
  logic signed [DW-1:0]   j_vmax [NJ];
  logic signed [DW-1:0]   j_acc [NJ];
  logic signed [DW-1:0]   j_lo [NJ];
  logic signed [DW-1:0]   j_hi [NJ];

  pos_item_t              pending_positions [$];
  int                     mismatches = 0;
  int                     useful_items = 0;
  int                     burst_left = 0;
  int                     idle_cycles = 0;

  joint_velocity_ramp_integrator_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind_i),
    .joint_i        (joint_i),
    .value_i        (value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_joint_o    (out_joint_o),
    .position_cmd_o (position_cmd_o),
    .last_o         (last_o),
    .cfg_wr_en_i    (cfg_wr_en_i),
    .cfg_wr_data_i  (cfg_wr_data_i)
  );

  always #2 clk_i = ~clk_i;

  // Clips a wide sum back into the signed data word.
  function automatic logic signed [DW-1:0] sat_sum(input longint v);
    if (v > longint'(W_MAX)) return W_MAX;
    if (v < longint'(W_MIN)) return W_MIN;
    return v[DW-1:0];
  endfunction

  // Q4.27 times the unsigned Q0.32 period; the arithmetic shift floors.
  function automatic logic signed [DW-1:0] scale_by_period(input logic signed [DW-1:0] v);
    longint prod;
    prod = longint'(v) * longint'({32'd0, period_q});
    prod = prod >>> 32;
    return prod[DW-1:0];
  endfunction

  // Applies one item to the joint state. A tick returns the number of new
  // positions, one per joint; a setting item returns zero.
  function automatic int apply_command(input logic [2:0] kind, input logic [2:0] jnt,
                                       input logic signed [DW-1:0] value,
                                       output logic signed [DW-1:0] new_pos [NJ]);
    logic signed [DW-1:0] step;
    logic signed [DW-1:0] cmd;
    logic signed [DW-1:0] pos;
    logic signed [DW-1:0] lim;
    int n;
    n = 0;
    for (int i = 0; i < NJ; i++) new_pos[i] = '0;
    if (kind == KIND_TICK) begin
      for (int i = 0; i < NJ; i++) begin
        // A negative acceleration leaves the velocity where it is.
        step = (j_acc[i] < 0) ? '0 : scale_by_period(j_acc[i]);
        cmd = j_vel[i];
        // Ramp without overshoot; equal speeds fall into the slow-down arm.
        if (longint'(j_des[i]) - longint'(cmd) > 0) begin
          cmd = sat_sum(longint'(cmd) + longint'(step));
          if (cmd > j_des[i]) cmd = j_des[i];
        end else begin
          cmd = sat_sum(longint'(cmd) - longint'(step));
          if (cmd < j_des[i]) cmd = j_des[i];
        end
        j_vel[i] = cmd;
        pos = sat_sum(longint'(j_pos[i]) + longint'(scale_by_period(cmd)));
        if (i == WRAP) begin
          if (pos < j_lo[i]) pos = sat_sum(longint'(pos) + longint'(TWO_PI_Q27));
          if (pos > j_hi[i]) pos = sat_sum(longint'(pos) - longint'(TWO_PI_Q27));
        end else begin
          if (pos < j_lo[i]) pos = j_lo[i];
          if (pos > j_hi[i]) pos = j_hi[i];
        end
        j_pos[i] = pos;
        new_pos[i] = pos;
      end
      n = NJ;
    end else if (jnt < NJ) begin
      case (kind)
        KIND_VEL_DES: begin
          lim = (j_vmax[jnt] < 0) ? '0 : j_vmax[jnt];
          if (value > lim) j_des[jnt] = lim;
          else if (value < -lim) j_des[jnt] = -lim;
          else j_des[jnt] = value;
        end
        KIND_POS:     j_pos[jnt] = value;
        KIND_VEL_MAX: j_vmax[jnt] = value;
        KIND_ACCEL:   j_acc[jnt] = value;
        KIND_LOWER:   j_lo[jnt] = value;
        KIND_UPPER:   j_hi[jnt] = value;
        default: ;
      endcase
    end
    return n;
  endfunction

  // Offers one item to the block. The sender works in bursts: when a burst
  // runs out, valid drops for a random gap and the payload is scrambled.
  // Valid then stays high, with the payload held, until the item is taken.
  task automatic send_item(input logic [2:0] kind, input logic [2:0] jnt,
                           input logic signed [DW-1:0] value, input int typed_ref);
    logic signed [DW-1:0] new_pos [NJ];
    int n;
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      kind_i <= 3'($urandom);
      joint_i <= 3'($urandom);
      value_i <= $urandom;
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6))
        @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? 24 : $urandom_range(1, 6);
    end
    in_valid_i <= 1'b1;
    kind_i <= kind;
    joint_i <= jnt;
    value_i <= value;
    do @(posedge clk_i); while (in_stall_o);
    burst_left--;
    n = apply_command(kind, jnt, value, new_pos);
    for (int i = 0; i < n; i++) begin
      pending_positions.push_back('{jnt: 3'(i),
                                    pos: (typed_ref == PREDICTED) ? new_pos[i]
                                                                  : TYPED_POS[typed_ref][i],
                                    last: (i == NJ - 1)});
    end
    if (kind == KIND_TICK || (kind != KIND_UNUSED && jnt < NJ)) useful_items++;
  endtask

  // Lowers valid, lets every outstanding position arrive, then waits out a
  // full joint step so that the block is certainly idle.
  task automatic drain_and_pause();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (pending_positions.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic load_period(input logic [PERIOD_W-1:0] p);
    drain_and_pause();
    cfg_wr_en_i <= 1'b1;
    cfg_wr_data_i <= p;
    @(posedge clk_i);
    period_q = p;
    cfg_wr_en_i <= 1'b0;
    cfg_wr_data_i <= $urandom;
  endtask

  // Full-scale words, small Q4.27 values of a few radians either side of
  // zero, and fully random words.
  function automatic logic signed [DW-1:0] pick_word();
    case ($urandom_range(0, 7))
      0: return W_MAX;
      1: return W_MIN;
      2: return '0;
      3, 4: return DW'(int'($urandom_range(0, 32'h4000_0000)) - 32'sh2000_0000);
      default: return $urandom;
    endcase
  endfunction

  // Speeds and accelerations: mostly positive and of a useful size, with
  // the odd extreme or negative one.
  function automatic logic signed [DW-1:0] pick_rate();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return W_MAX;
      2: return '0;
      default: return DW'($urandom_range(0, 32'h2000_0000));
    endcase
  endfunction

  // A well-formed move on one joint: maybe limits (mostly in order), a new
  // position, a speed limit and an acceleration, then a target speed and a few ticks.
  task automatic send_motion();
    logic [2:0] j;
    logic signed [DW-1:0] lo;
    logic signed [DW-1:0] hi;
    logic signed [DW-1:0] t;
    j = 3'($urandom_range(0, NJ - 1));
    lo = pick_word();
    hi = pick_word();
    if (lo > hi && $urandom_range(0, 4) != 0) begin
      t = lo;
      lo = hi;
      hi = t;
    end
    if ($urandom_range(0, 2) != 0) send_item(KIND_LOWER, j, lo, PREDICTED);
    if ($urandom_range(0, 2) != 0) send_item(KIND_UPPER, j, hi, PREDICTED);
    if ($urandom_range(0, 3) == 0) send_item(KIND_POS, j, pick_word(), PREDICTED);
    if ($urandom_range(0, 1) != 0) send_item(KIND_VEL_MAX, j, pick_rate(), PREDICTED);
    if ($urandom_range(0, 1) != 0) send_item(KIND_ACCEL, j, pick_rate(), PREDICTED);
    if ($urandom_range(0, 3) == 0) begin
      send_item(KIND_VEL_DES, j, pick_word(), PREDICTED);
    end else begin
      t = pick_rate();
      send_item(KIND_VEL_DES, j, ($urandom_range(0, 1) != 0) ? t : -t, PREDICTED);
    end
    repeat ($urandom_range(1, 3)) send_item(KIND_TICK, 3'($urandom), $urandom, PREDICTED);
  endtask

  // The receiver changes its habit now and then: flowing freely, held off
  // solid, tossing a coin each cycle, or stalling only now and then.
  initial begin : receiver_stall
    rx_mode_e mode;
    int left;
    out_stall_i <= 1'b0;
    mode = RX_FLOW;
    left = 0;
    forever begin
      @(posedge clk_i);
      if (left == 0) begin
        mode = rx_mode_e'($urandom_range(0, 3));
        left = (mode == RX_HOLD) ? $urandom_range(1, 30) : $urandom_range(10, 200);
      end
      left--;
      case (mode)
        RX_FLOW:  out_stall_i <= 1'b0;
        RX_HOLD:  out_stall_i <= 1'b1;
        RX_COIN:  out_stall_i <= 1'($urandom_range(0, 1));
        default:  out_stall_i <= ($urandom_range(0, 5) == 0);
      endcase
    end
  end

  // Every output item taken is checked against the oldest position in store.
  always @(posedge clk_i) begin
    pos_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_positions.size() == 0) begin
        $display("%0t ns: position item with nothing expected: joint %0d, position %0d, last %0b",
                 $time, out_joint_o, position_cmd_o, last_o);
        mismatches++;
      end else begin
        want = pending_positions.pop_front();
        if (out_joint_o !== want.jnt) begin
          $display("%0t ns: out_joint expected %0d, got %0d", $time, want.jnt, out_joint_o);
          mismatches++;
        end
        if (position_cmd_o !== want.pos) begin
          $display("%0t ns: position_cmd of joint %0d expected %0d (%h), got %0d (%h)",
                   $time, want.jnt, want.pos, want.pos, position_cmd_o, position_cmd_o);
          mismatches++;
        end
        if (last_o !== want.last) begin
          $display("%0t ns: last of joint %0d expected %0b, got %0b",
                   $time, want.jnt, want.last, last_o);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: too long without any item moving on either side means a hang.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("** joint_velocity_ramp_integrator_unit: FAILED **");
      $finish;
    end
  end

  initial begin
    logic [PERIOD_W-1:0] next_period;
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    kind_i <= '0;
    joint_i <= '0;
    value_i <= '0;
    cfg_wr_en_i <= 1'b0;
    cfg_wr_data_i <= '0;
    period_q = PERIOD_RESET;
    for (int i = 0; i < NJ; i++) begin
      j_pos[i] = '0;
      j_vel[i] = '0;
      j_des[i] = '0;
      j_vmax[i] = '0;
      j_acc[i] = '0;
      j_lo[i] = '0;
      j_hi[i] = '0;
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed script at the reset period.
    for (int r = 0; r < $size(SCRIPT); r++) begin
      send_item(SCRIPT[r].kind, SCRIPT[r].jnt, SCRIPT[r].value, SCRIPT[r].typed_ref);
    end

    // Random phases, each at its own period: the full-scale period of about
    // a second and a zero period first, then assorted values in between.
    useful_items = 0;
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: next_period = 32'hFFFF_FFFF;
        1: next_period = 32'd0;
        2: next_period = 32'h1000_0000;
        3: next_period = $urandom;
        4: next_period = 32'h8000_0000;
        default: next_period = $urandom_range(1, 32'h00FF_FFFF);
      endcase
      load_period(next_period);
      while (useful_items < (ph + 1) * RANDOM_ITEMS / PHASES) begin
        if ($urandom_range(0, 9) < 7) send_motion();
        else send_item(3'($urandom), 3'($urandom), $urandom, PREDICTED);
      end
    end

    in_valid_i <= 1'b0;
    while (pending_positions.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("** joint_velocity_ramp_integrator_unit: PASSED **");
    end else begin
      $display("** joint_velocity_ramp_integrator_unit: FAILED **");
    end
    $finish;
  end

endmodule
